// ===== hw/rtl/thas_pkg.sv =====
package thas_pkg;

  // frame geometry
  localparam int FRAME_WIDTH  = 32;
  localparam int FRAME_HEIGHT = 32;
  localparam int COL_W        = $clog2(FRAME_WIDTH);
  localparam int ROW_W        = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

  // field widths
  localparam int PIX_W     = 8;
  localparam int DUR_W     = 16;
  localparam int THR_W     = 8;
  localparam int GAIN_W    = 16;
  localparam int REQ_W     = 8;
  localparam int BAND_W    = 5;
  localparam int COUNT_W   = 8;
  localparam int ELAPSED_W = 17;
  localparam int RATE_W    = 21;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  // distance and rate arithmetic
  localparam int DIST_W = (COL_W + 1 > BAND_W) ? COL_W + 1 : BAND_W;
  localparam int PROD_W = COL_W + 2 + GAIN_W + 1;
  localparam int RATE_LIMIT = 1048560;

  // register reset values
  localparam logic [THR_W-1:0]  THR_RST  = THR_W'(45);
  localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(1638);
  localparam logic [REQ_W-1:0]  REQ_RST  = REQ_W'(5);
  localparam logic [BAND_W-1:0] BAND_RST = BAND_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRE_THRESHOLD  = 2'd0,
    REG_TURN_GAIN       = 2'd1,
    REG_FRAMES_REQUIRED = 2'd2,
    REG_CENTRE_BAND     = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_PIXEL   = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_PREEMPT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_TURNING  = 2'd1,
    MODE_SPRAYING = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    OUTCOME_NONE    = 2'd0,
    OUTCOME_SUCCESS = 2'd1,
    OUTCOME_FAILED  = 2'd2
  } outcome_t;

endpackage

// ===== hw/rtl/thermal_hotspot_aim_and_spray_core.sv =====
// path: an accepted item passes the read stage, the rate stage and the output register before its result is offered
// throughput: one item per cycle while the output is not stalled, set by the single read-modify-write per pixel
//   on the column-peak memory (read at accept, written back in the execute stage)
// reset: rst_n is synchronous and active low; it clears control state and loads
//   the register defaults; the column-peak memory is not cleared, the first row
//   of every frame overwrites it
module thermal_hotspot_aim_and_spray_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [thas_pkg::IN_DATA_W-1:0]    in_tdata,   // pixel_value[7:0], duration_ms[23:8]
  input  logic [1:0]                        in_tuser,   // cmd[1:0]
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // phase[1:0], pump_on[2], turn_rate[23:3], rate_update[24], outcome[26:25], zero[31:27]
  output logic [thas_pkg::OUT_DATA_W-1:0]   out_tdata,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [thas_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [thas_pkg::CFG_DAT_W-1:0]    cfg_wdata
);
  import thas_pkg::*;

  // configuration registers
  logic [THR_W-1:0]  thr_r;
  logic [GAIN_W-1:0] gain_r;
  logic [REQ_W-1:0]  req_r;
  logic [BAND_W-1:0] band_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RST;
      gain_r <= GAIN_RST;
      req_r  <= REQ_RST;
      band_r <= BAND_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FIRE_THRESHOLD:  thr_r  <= cfg_wdata[THR_W-1:0];
        REG_TURN_GAIN:       gain_r <= cfg_wdata[GAIN_W-1:0];
        REG_FRAMES_REQUIRED: req_r  <= cfg_wdata[REQ_W-1:0];
        REG_CENTRE_BAND:     band_r <= cfg_wdata[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control: read stage, execute into rate stage, output register
  logic s1_valid_r, m_valid_r, out_valid_r;
  logic exec, m_adv, in_xfer;

  assign m_adv   = m_valid_r && (!out_valid_r || out_tready);
  assign exec    = s1_valid_r && (!m_valid_r || m_adv);
  assign in_tready = !s1_valid_r || exec;
  assign in_xfer = in_tvalid && in_tready;

  // committed block state
  mode_t                mode_r, mode_nxt;
  logic [COL_W-1:0]     col_r, col_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [COL_W-1:0]     bc_r, bc_nxt;
  logic [PIX_W-1:0]     bv_r, bv_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [DUR_W-1:0]     spray_r, spray_nxt;

  // read stage payload
  cmd_t             s1_cmd_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [DUR_W-1:0] s1_dur_r;
  logic [PIX_W-1:0] rd_r;

  // column-peak memory
  logic [PIX_W-1:0] peak_mem [FRAME_WIDTH];
  logic             mem_we;
  logic [PIX_W-1:0] mem_wdata;
  logic [COL_W-1:0] col_fwd;

  // the column of an arriving item follows the item executing in the same cycle
  assign col_fwd = exec ? col_nxt : col_r;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_r <= peak_mem[col_fwd];
    end
    if (exec && mem_we) begin
      peak_mem[col_r] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r <= cmd_t'(in_tuser);
      s1_pix_r <= in_tdata[PIX_W-1:0];
      s1_dur_r <= in_tdata[PIX_W +: DUR_W];
    end
  end

  // execute stage results
  outcome_t                res_outcome;
  logic                    res_upd;
  logic                    res_fire;
  logic signed [COL_W:0]   res_d;

  always_comb begin
    logic [PIX_W-1:0]       peak_new;
    logic [PIX_W-1:0]       bv_base;
    logic [COL_W-1:0]       bc_base;
    logic [PIX_W-1:0]       bv_eval;
    logic [COL_W-1:0]       bc_eval;
    logic signed [COL_W:0]  d;
    logic [COL_W:0]         col_dist;
    logic                   centred;
    logic                   last_col, last_row;
    logic [ELAPSED_W-1:0]   elapsed_inc;

    mode_nxt    = mode_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    bc_nxt      = bc_r;
    bv_nxt      = bv_r;
    count_nxt   = count_r;
    elapsed_nxt = elapsed_r;
    spray_nxt   = spray_r;
    mem_we      = 1'b0;
    res_outcome = OUTCOME_NONE;
    res_upd     = 1'b0;
    res_fire    = 1'b0;

    last_col = (col_r == COL_W'(FRAME_WIDTH - 1));
    last_row = (row_r == ROW_W'(FRAME_HEIGHT - 1));

    // first row overwrites, later rows keep the maximum
    peak_new  = ((row_r == '0) || (s1_pix_r > rd_r)) ? s1_pix_r : rd_r;
    mem_wdata = peak_new;

    // running hottest column over the last row, restarting at column zero
    bv_base = (col_r == '0) ? '0 : bv_r;
    bc_base = (col_r == '0) ? '0 : bc_r;
    if (peak_new > bv_base) begin
      bv_eval = peak_new;
      bc_eval = col_r;
    end else begin
      bv_eval = bv_base;
      bc_eval = bc_base;
    end

    d        = $signed({1'b0, bc_eval}) - $signed((COL_W + 1)'(FRAME_WIDTH / 2));
    col_dist = d[COL_W] ? (COL_W + 1)'(-d) : (COL_W + 1)'(d);
    centred  = (DIST_W'(col_dist) < DIST_W'(band_r));
    res_d    = d;

    elapsed_inc = elapsed_r + ELAPSED_W'(1);

    unique case (s1_cmd_r)
      CMD_START: begin
        mode_nxt    = MODE_TURNING;
        col_nxt     = '0;
        row_nxt     = '0;
        bc_nxt      = '0;
        bv_nxt      = '0;
        count_nxt   = '0;
        elapsed_nxt = '0;
        spray_nxt   = s1_dur_r;
      end
      CMD_PIXEL: begin
        if (mode_r == MODE_TURNING) begin
          mem_we = 1'b1;
          if (last_row) begin
            bv_nxt = bv_eval;
            bc_nxt = bc_eval;
          end
          if (last_col) begin
            col_nxt = '0;
            row_nxt = last_row ? '0 : row_r + ROW_W'(1);
          end else begin
            col_nxt = col_r + COL_W'(1);
          end
          // end of frame: decide the rate or start spraying
          if (last_col && last_row) begin
            if (bv_eval < thr_r) begin
              res_upd = 1'b1;
            end else if (centred && (count_r >= req_r)) begin
              mode_nxt    = MODE_SPRAYING;
              elapsed_nxt = '0;
            end else begin
              if (centred) begin
                count_nxt = count_r + COUNT_W'(1);
              end
              res_upd  = 1'b1;
              res_fire = 1'b1;
            end
          end
        end
      end
      CMD_TICK: begin
        if (mode_r == MODE_SPRAYING) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc > ELAPSED_W'(spray_r)) begin
            mode_nxt    = MODE_IDLE;
            res_outcome = OUTCOME_SUCCESS;
          end
        end
      end
      CMD_PREEMPT: begin
        if (mode_r != MODE_IDLE) begin
          mode_nxt    = MODE_IDLE;
          res_outcome = OUTCOME_FAILED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      col_r     <= '0;
      row_r     <= '0;
      bc_r      <= '0;
      bv_r      <= '0;
      count_r   <= '0;
      elapsed_r <= '0;
      spray_r   <= '0;
    end else if (exec) begin
      mode_r    <= mode_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      bc_r      <= bc_nxt;
      bv_r      <= bv_nxt;
      count_r   <= count_nxt;
      elapsed_r <= elapsed_nxt;
      spray_r   <= spray_nxt;
    end
  end

  // rate stage payload
  mode_t                 m_phase_r;
  outcome_t              m_outcome_r;
  logic                  m_upd_r;
  logic                  m_fire_r;
  logic signed [COL_W:0] m_d_r;

  always_ff @(posedge clk) begin
    if (exec) begin
      m_phase_r   <= mode_nxt;
      m_outcome_r <= res_outcome;
      m_upd_r     <= res_upd;
      m_fire_r    <= res_fire;
      m_d_r       <= res_d;
    end
  end

  // rate = -d * gain, saturated
  logic signed [COL_W+1:0]  neg_d;
  logic signed [PROD_W-1:0] prod;
  logic signed [31:0]       prod32;
  logic [RATE_W-1:0]        rate_sat;

  assign neg_d  = -($signed({m_d_r[COL_W], m_d_r}));
  assign prod   = PROD_W'(neg_d) * PROD_W'($signed({1'b0, gain_r}));
  assign prod32 = 32'(prod);

  always_comb begin
    if (!m_fire_r) begin
      rate_sat = '0;
    end else if (prod32 > 32'sd1048560) begin
      rate_sat = RATE_W'(RATE_LIMIT);
    end else if (prod32 < -32'sd1048560) begin
      rate_sat = RATE_W'(-RATE_LIMIT);
    end else begin
      rate_sat = prod32[RATE_W-1:0];
    end
  end

  // output register
  mode_t             out_phase_r;
  logic              out_pump_r;
  logic [RATE_W-1:0] out_rate_r;
  logic              out_upd_r;
  outcome_t          out_outcome_r;

  always_ff @(posedge clk) begin
    if (m_adv) begin
      out_phase_r   <= m_phase_r;
      out_pump_r    <= (m_phase_r == MODE_SPRAYING);
      out_rate_r    <= rate_sat;
      out_upd_r     <= m_upd_r;
      out_outcome_r <= m_outcome_r;
    end
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      m_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (exec) begin
        s1_valid_r <= 1'b0;
      end
      if (exec) begin
        m_valid_r <= 1'b1;
      end else if (m_adv) begin
        m_valid_r <= 1'b0;
      end
      if (m_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_outcome_r, out_upd_r, out_rate_r, out_pump_r, out_phase_r};

endmodule
